>>> design/wcdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcdf_pkg
// Shared types and constants of the weighted CDF index sampler: operation and
// status codes, field widths, and the controller/datapath command and status
// bundles.
// ----------------------------------------------------------------------------
package wcdf_pkg;

  // Beat field widths
  localparam int OP_W       = 2;
  localparam int WEIGHT_W   = 32;
  localparam int FRAC_W     = 17;
  localparam int STATUS_W   = 2;
  localparam int PIDX_W     = 8;
  localparam int SUM_W      = 40;
  localparam int ECNT_W     = 9;
  localparam int IN_DATA_W  = 56;   // weight + fraction, padded to bytes
  localparam int OUT_DATA_W = 96;   // index + weight + total + count, padded

  // Fraction scale: 65536 means 1.0
  localparam int FRAC_SHIFT = 16;

  // The 40-bit total is multiplied in two 20-bit halves
  localparam int SPLIT_W = 20;
  localparam int MUL_W   = FRAC_W + SPLIT_W;  // one partial product
  localparam int TGT_W   = FRAC_W + SUM_W;    // full u * total

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } wcdf_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RSVD  = 2'd3
  } wcdf_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SRCH_INIT,
    ST_SRCH,
    ST_PICK,
    ST_PREV,
    ST_WEIGHT,
    ST_DONE
  } wcdf_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;        // input beat accepted this cycle
    logic do_clear;    // empty the table
    logic do_append;   // store a new running sum
    logic set_full;    // append refused
    logic set_empty;   // sample on empty table
    logic mul_lo;      // u * total[19:0]
    logic mul_hi;      // u * total[39:20]
    logic srch_init;   // finish target, issue first probe
    logic srch_step;   // compare probe, narrow the range
    logic pick;        // clamp index, read its sum
    logic get_prev;    // latch sum, read previous sum
    logic get_weight;  // form picked weight
    logic load_out;    // move result into output register
  } wcdf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tbl_empty;
    logic tbl_full;
    logic srch_more;   // range still open after this probe
    logic out_free;    // output register can take a result
  } wcdf_sts_t;

endpackage

>>> design/weighted_cdf_index_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_cdf_index_sampler
// Discrete sampler by inverse CDF: keeps a table of running weight sums and
// binary-searches it for the first sum with sum * 65536 >= u * total.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  in_      in   tuser: operation; tdata: weight, fraction
//  out_     out  tuser: status; tdata: index, weight, total, count
//
//  Clear, append, no-op, empty-table sample: accept, done, result register.
//  Sample: both multiply halves, search init, k search probes, k at most
//  ceil(log2(count + 1)), pick, previous sum, weight, done; one probe per cycle
//  on the single read port of the sum memory. Next beat is taken once the
//  result is in the output register, even while that result is still stalled.
//  Reset clears count and total; the sum memory needs no clearing.
// ----------------------------------------------------------------------------
module weighted_cdf_index_sampler #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wcdf_pkg::OP_W-1:0]           in_tuser,   // [1:0] operation
  input  logic [wcdf_pkg::IN_DATA_W-1:0]      in_tdata,   // [31:0] weight,
                                                          // [48:32] fraction
  // result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wcdf_pkg::STATUS_W-1:0]       out_tuser,  // [1:0] status
  output logic [wcdf_pkg::OUT_DATA_W-1:0]     out_tdata   // [7:0] picked_index,
                                                          // [39:8] picked_weight,
                                                          // [79:40] weight_total,
                                                          // [88:80] entry_count
);

  wcdf_pkg::wcdf_cmd_t cmd;
  wcdf_pkg::wcdf_sts_t sts;
  wcdf_pkg::wcdf_op_e  in_op;

  assign in_op = wcdf_pkg::wcdf_op_e'(in_tuser);

  wcdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_op),
    .sts       (sts),
    .cmd       (cmd)
  );

  wcdf_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_weight   (in_tdata[wcdf_pkg::WEIGHT_W-1:0]),
    .in_fraction (in_tdata[wcdf_pkg::WEIGHT_W +: wcdf_pkg::FRAC_W]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (out_tuser),
    .out_data    (out_tdata)
  );

`ifndef SYNTHESIS
  // A result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a stalled result");

  // Datapath steps never overlap
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_clear, cmd.do_append, cmd.mul_lo, cmd.mul_hi, cmd.srch_init,
              cmd.srch_step, cmd.pick, cmd.get_prev, cmd.get_weight, cmd.load_out}))
    else $error("overlapping datapath steps");

  // A sample on a filled table starts the target multiply next cycle
  a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op == wcdf_pkg::OP_SAMPLE && !sts.tbl_empty)
      |=> cmd.mul_lo)
    else $error("sample did not start the search");
`endif

endmodule

>>> design/wcdf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcdf_ctrl
// Sequencer of the sampler: decodes each input beat and steps the datapath
// through target multiply, binary search, weight readout and result load.
// ----------------------------------------------------------------------------
module wcdf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  wcdf_pkg::wcdf_op_e   in_op,
  input  wcdf_pkg::wcdf_sts_t  sts,
  output wcdf_pkg::wcdf_cmd_t  cmd
);

  wcdf_pkg::wcdf_state_e state_r;
  wcdf_pkg::wcdf_state_e state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcdf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wcdf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_op == wcdf_pkg::OP_SAMPLE && !sts.tbl_empty) begin
            state_nxt = wcdf_pkg::ST_MUL_LO;
          end else begin
            state_nxt = wcdf_pkg::ST_DONE;
          end
        end
      end
      wcdf_pkg::ST_MUL_LO:    state_nxt = wcdf_pkg::ST_MUL_HI;
      wcdf_pkg::ST_MUL_HI:    state_nxt = wcdf_pkg::ST_SRCH_INIT;
      wcdf_pkg::ST_SRCH_INIT: state_nxt = wcdf_pkg::ST_SRCH;
      wcdf_pkg::ST_SRCH: begin
        if (!sts.srch_more) begin
          state_nxt = wcdf_pkg::ST_PICK;
        end
      end
      wcdf_pkg::ST_PICK:      state_nxt = wcdf_pkg::ST_PREV;
      wcdf_pkg::ST_PREV:      state_nxt = wcdf_pkg::ST_WEIGHT;
      wcdf_pkg::ST_WEIGHT:    state_nxt = wcdf_pkg::ST_DONE;
      wcdf_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = wcdf_pkg::ST_IDLE;
        end
      end
      default:                state_nxt = wcdf_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      wcdf_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.take      = in_tvalid;
        cmd.do_clear  = in_tvalid && (in_op == wcdf_pkg::OP_CLEAR);
        cmd.do_append = in_tvalid && (in_op == wcdf_pkg::OP_APPEND) && !sts.tbl_full;
        cmd.set_full  = in_tvalid && (in_op == wcdf_pkg::OP_APPEND) && sts.tbl_full;
        cmd.set_empty = in_tvalid && (in_op == wcdf_pkg::OP_SAMPLE) && sts.tbl_empty;
      end
      wcdf_pkg::ST_MUL_LO:    cmd.mul_lo     = 1'b1;
      wcdf_pkg::ST_MUL_HI:    cmd.mul_hi     = 1'b1;
      wcdf_pkg::ST_SRCH_INIT: cmd.srch_init  = 1'b1;
      wcdf_pkg::ST_SRCH:      cmd.srch_step  = 1'b1;
      wcdf_pkg::ST_PICK:      cmd.pick       = 1'b1;
      wcdf_pkg::ST_PREV:      cmd.get_prev   = 1'b1;
      wcdf_pkg::ST_WEIGHT:    cmd.get_weight = 1'b1;
      wcdf_pkg::ST_DONE:      cmd.load_out   = sts.out_free;
      default:                cmd            = '0;
    endcase
  end

endmodule

>>> design/wcdf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcdf_dp
// Datapath of the sampler: running-sum memory, total and count registers,
// split multiplier for u * total, binary-search range registers and the
// output register.
// ----------------------------------------------------------------------------
module wcdf_dp #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wcdf_pkg::wcdf_cmd_t                 cmd,
  output wcdf_pkg::wcdf_sts_t                 sts,
  input  logic [wcdf_pkg::WEIGHT_W-1:0]       in_weight,
  input  logic [wcdf_pkg::FRAC_W-1:0]         in_fraction,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wcdf_pkg::STATUS_W-1:0]       out_status,
  output logic [wcdf_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = wcdf_pkg::SUM_W;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Table state
  logic [SUM_W-1:0]               sum_mem_r [MAX_ENTRIES];
  logic [SUM_W-1:0]               rd_data_r;
  logic [AW-1:0]                  rd_addr;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [SUM_W-1:0]               sum_r, sum_nxt;
  logic [SUM_W:0]                 sum_add;

  // Search and result working registers
  logic [wcdf_pkg::FRAC_W-1:0]    frac_r;
  logic [wcdf_pkg::SPLIT_W-1:0]   mul_src;
  logic [wcdf_pkg::MUL_W-1:0]     mul_r;
  logic [wcdf_pkg::TGT_W-1:0]     tgt_r;
  logic [CW-1:0]                  lo_r, hi_r, mid_r;
  logic [CW-1:0]                  lo_nxt, hi_nxt, mid_nxt;
  logic [AW-1:0]                  idx_r;
  logic [CW-1:0]                  idx_pick;
  logic [SUM_W-1:0]               cur_r, prev_sum, diff;
  logic [wcdf_pkg::STATUS_W-1:0]  status_r;
  logic [wcdf_pkg::PIDX_W-1:0]    pidx_r;
  logic [wcdf_pkg::WEIGHT_W-1:0]  pw_r;
  logic                           probe_ge;
  logic                           more_ge, more_lt;
  logic [CW-1:0]                  mid_p1;
  logic [AW+wcdf_pkg::PIDX_W-1:0] idx_ext;
  logic [CW+wcdf_pkg::ECNT_W-1:0] cnt_ext;

  // Output register
  logic                            out_valid_r;
  logic [wcdf_pkg::STATUS_W-1:0]   out_status_r;
  logic [wcdf_pkg::OUT_DATA_W-1:0] out_data_r;

  // Status toward controller
  assign sts.tbl_empty = (count_r == '0);
  assign sts.tbl_full  = (count_r >= CW'(MAX_ENTRIES));
  assign sts.out_free  = !out_valid_r || out_tready;

  // Saturating append sum
  assign sum_add = {1'b0, sum_r} + {{(SUM_W + 1 - wcdf_pkg::WEIGHT_W){1'b0}}, in_weight};

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (cmd.do_clear) begin
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (cmd.do_append) begin
      count_nxt = count_r + CW'(1);
      sum_nxt   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Probe compare: sums[mid] * 65536 >= u * total
  assign probe_ge = {1'b0, rd_data_r, {wcdf_pkg::FRAC_SHIFT{1'b0}}} >= tgt_r;
  assign mid_p1   = mid_r + CW'(1);
  assign more_ge  = lo_r < mid_r;
  assign more_lt  = mid_p1 < hi_r;
  assign sts.srch_more = probe_ge ? more_ge : more_lt;

  // Both candidate next ranges, chosen by the compare
  always_comb begin
    if (probe_ge) begin
      lo_nxt  = lo_r;
      hi_nxt  = mid_r;
      mid_nxt = lo_r + ((mid_r - lo_r) >> 1);
    end else begin
      lo_nxt  = mid_p1;
      hi_nxt  = hi_r;
      mid_nxt = mid_p1 + ((hi_r - mid_p1) >> 1);
    end
  end

  // Clamp to last entry when nothing matched
  assign idx_pick = (lo_r >= count_r) ? (count_r - CW'(1)) : lo_r;

  // Memory read address
  always_comb begin
    rd_addr = '0;
    if (cmd.srch_init) begin
      rd_addr = AW'(count_r >> 1);
    end else if (cmd.srch_step) begin
      rd_addr = mid_nxt[AW-1:0];
    end else if (cmd.pick) begin
      rd_addr = idx_pick[AW-1:0];
    end else if (cmd.get_prev) begin
      rd_addr = idx_r - AW'(1);
    end
  end

  // Running-sum memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.do_append) begin
      sum_mem_r[count_r[AW-1:0]] <= sum_nxt;
    end
    rd_data_r <= sum_mem_r[rd_addr];
  end

  // u * total in two halves, one partial product per cycle
  assign mul_src = cmd.mul_hi ? sum_r[SUM_W-1:wcdf_pkg::SPLIT_W]
                              : sum_r[wcdf_pkg::SPLIT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      frac_r <= in_fraction;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      mul_r <= wcdf_pkg::MUL_W'(frac_r) * wcdf_pkg::MUL_W'(mul_src);
    end
    if (cmd.mul_hi) begin
      tgt_r <= wcdf_pkg::TGT_W'(mul_r);
    end else if (cmd.srch_init) begin
      tgt_r <= tgt_r + {mul_r, {wcdf_pkg::SPLIT_W{1'b0}}};
    end
  end

  // Search range
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo_r  <= '0;
      hi_r  <= count_r;
      mid_r <= count_r >> 1;
    end else if (cmd.srch_step) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt;
    end
  end

  // Picked weight: sums[i] - sums[i-1]
  assign prev_sum = (idx_r == '0) ? '0 : rd_data_r;
  assign diff     = cur_r - prev_sum;
  assign idx_ext  = {{wcdf_pkg::PIDX_W{1'b0}}, idx_r};

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      idx_r <= idx_pick[AW-1:0];
    end
    if (cmd.get_prev) begin
      cur_r <= rd_data_r;
    end
    if (cmd.take) begin
      status_r <= cmd.set_full  ? wcdf_pkg::STAT_FULL  :
                  cmd.set_empty ? wcdf_pkg::STAT_EMPTY : wcdf_pkg::STAT_OK;
      pidx_r   <= '0;
      pw_r     <= '0;
    end else if (cmd.get_weight) begin
      pidx_r   <= idx_ext[wcdf_pkg::PIDX_W-1:0];
      pw_r     <= diff[wcdf_pkg::WEIGHT_W-1:0];
    end
  end

  // Output register
  assign cnt_ext = {{wcdf_pkg::ECNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_data_r   <= {7'b0, cnt_ext[wcdf_pkg::ECNT_W-1:0], sum_r, pw_r, pidx_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;

endmodule
